/* rtl/gnl_pkg.sv */
// shared types and constants of the grid neighbourhood locator
`default_nettype none
package gnl_pkg;

  localparam int MAX_GRID_DIM_DEF = 1024;
  localparam int DIM_W = 11;
  localparam int SIZE_W = 16;
  localparam int CS_W = 8;
  localparam int CELL_W = 21;
  localparam int IDX_W = 20;
  localparam int TOTAL_W = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MIN_CELL = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCENE_LENGTH = 2'd0,
    REG_SCENE_WIDTH  = 2'd1,
    REG_CELL_SIZE    = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    ACT_LOCATE = 1'b0,
    ACT_NEIGHBOURS = 1'b1
  } action_t;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] pos_x;
    logic [SIZE_W-1:0] pos_y;
    logic [CELL_W-1:0] first_cell;
    logic [CELL_W-1:0] second_cell;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cell_index;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic               busy;
    logic [CS_W-1:0]    cell_size;
    logic [DIM_W-1:0]   column_count;
    logic [DIM_W-1:0]   row_count;
    logic [TOTAL_W-1:0] total;
  } grid_status_t;

endpackage
`default_nettype wire

/* rtl/gnl_grid_calc.sv */
// configuration registers and serial recomputation of the grid dimensions
`default_nettype none
module gnl_grid_calc import gnl_pkg::*; #(
  parameter int MaxGridDim = MAX_GRID_DIM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output grid_status_t               status
);

  typedef enum logic [2:0] {
    CALC_IDLE,
    CALC_LOAD,
    CALC_DIV,
    CALC_SET,
    CALC_TOTAL
  } calc_state_t;

  calc_state_t        state_r;
  logic [SIZE_W-1:0]  len_r, wid_r;
  logic [CS_W-1:0]    cs_r;
  logic [DIM_W-1:0]   cc_r, rc_r;
  logic [TOTAL_W-1:0] total_r;
  logic [SIZE_W-1:0]  nl_r, nw_r;
  logic [CS_W-1:0]    rl_r, rw_r;
  logic [3:0]         cnt_r;

  logic [CS_W:0]      tl, tw, dl_sub, dw_sub;
  logic               gel, gew;
  logic [SIZE_W:0]    ql, qw;
  logic [DIM_W-1:0]   cc_nxt, rc_nxt;
  logic [CS_W-1:0]    cs_wr;

  always_comb begin
    tl = {rl_r, nl_r[SIZE_W-1]};
    tw = {rw_r, nw_r[SIZE_W-1]};
    gel = tl >= {1'b0, cs_r};
    gew = tw >= {1'b0, cs_r};
    dl_sub = tl - {1'b0, cs_r};
    dw_sub = tw - {1'b0, cs_r};
    ql = {1'b0, nl_r} + (SIZE_W+1)'(1);
    qw = {1'b0, nw_r} + (SIZE_W+1)'(1);
    cc_nxt = (ql > (SIZE_W+1)'(MaxGridDim)) ? DIM_W'(MaxGridDim) : ql[DIM_W-1:0];
    rc_nxt = (qw > (SIZE_W+1)'(MaxGridDim)) ? DIM_W'(MaxGridDim) : qw[DIM_W-1:0];
    cs_wr = (cfg_data[CS_W-1:0] < CS_W'(MIN_CELL)) ? CS_W'(MIN_CELL) : cfg_data[CS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CALC_IDLE;
      len_r <= SIZE_W'(1);
      wid_r <= SIZE_W'(1);
      cs_r <= CS_W'(MIN_CELL);
      cc_r <= DIM_W'(1);
      rc_r <= DIM_W'(1);
      total_r <= TOTAL_W'(1);
      cnt_r <= '0;
      nl_r <= '0;
      nw_r <= '0;
      rl_r <= '0;
      rw_r <= '0;
    end else begin
      unique case (state_r)
        CALC_IDLE: ;
        CALC_LOAD: begin
          nl_r <= (len_r == '0) ? '0 : len_r - SIZE_W'(1);
          nw_r <= (wid_r == '0) ? '0 : wid_r - SIZE_W'(1);
          rl_r <= '0;
          rw_r <= '0;
          cnt_r <= '0;
          state_r <= CALC_DIV;
        end
        CALC_DIV: begin
          nl_r <= {nl_r[SIZE_W-2:0], gel};
          nw_r <= {nw_r[SIZE_W-2:0], gew};
          rl_r <= gel ? dl_sub[CS_W-1:0] : tl[CS_W-1:0];
          rw_r <= gew ? dw_sub[CS_W-1:0] : tw[CS_W-1:0];
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'd15) begin
            state_r <= CALC_SET;
          end
        end
        CALC_SET: begin
          cc_r <= cc_nxt;
          rc_r <= rc_nxt;
          state_r <= CALC_TOTAL;
        end
        CALC_TOTAL: begin
          total_r <= TOTAL_W'(cc_r) * TOTAL_W'(rc_r);
          state_r <= CALC_IDLE;
        end
        default: state_r <= CALC_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCENE_LENGTH: begin
            len_r <= cfg_data;
            state_r <= CALC_LOAD;
          end
          REG_SCENE_WIDTH: begin
            wid_r <= cfg_data;
            state_r <= CALC_LOAD;
          end
          REG_CELL_SIZE: begin
            cs_r <= cs_wr;
            state_r <= CALC_LOAD;
          end
          default: ;
        endcase
      end
    end
  end

  assign status.busy = (state_r != CALC_IDLE);
  assign status.cell_size = cs_r;
  assign status.column_count = cc_r;
  assign status.row_count = rc_r;
  assign status.total = total_r;

endmodule
`default_nettype wire

/* rtl/grid_neighbourhood_locator_unit.sv */
// top level: divider pipeline, neighbourhood mask and result sequencer
//
//  channel   ports                         transfer when
//  input     start, busy, in_data          start high, busy low
//  result    out_strobe, out_data          out_strobe high, one cycle each
//  config    cfg_we, cfg_index, cfg_data   cfg_we high
//
// an item passes an entry stage and 21 one-bit divider stages, then loads the
// result sequencer
// the sequencer emits one result a cycle, up to nine per item; the pipeline
// moves only while the sequencer is on its final result or empty
// a register write recomputes the grid dimensions serially, busy meanwhile
// reset is synchronous and clears the pipeline and the configuration
`default_nettype none
module grid_neighbourhood_locator_unit import gnl_pkg::*; #(
  parameter int MaxGridDim = MAX_GRID_DIM_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire in_item_t              in_data,
  output logic                       out_strobe,
  output out_item_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DIV_STAGES = CELL_W;

  typedef struct packed {
    logic              valid;
    logic              action;
    logic              a_ok;
    logic              b_ok;
    logic [IDX_W-1:0]  a_idx;
    logic [CELL_W-1:0] na;
    logic [DIM_W-1:0]  ra;
    logic [CELL_W-1:0] nb;
    logic [DIM_W-1:0]  rb;
  } div_stage_t;

  grid_status_t status;
  div_stage_t   stg_r [0:DIV_STAGES];
  div_stage_t   stg_nxt [1:DIV_STAGES];
  logic [DIM_W-1:0] divisor;
  logic adv, accept;

  logic [8:0]       em_mask_r;
  logic [IDX_W-1:0] em_base_r [0:2];
  logic [8:0]       mask_rest;

  gnl_grid_calc #(.MaxGridDim(MaxGridDim)) u_calc (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .status(status)
  );

  assign mask_rest = em_mask_r & (em_mask_r - 9'd1);
  assign adv = (mask_rest == '0);
  assign busy = !adv || status.busy;
  assign accept = start && !busy;

  genvar k;
  generate
    for (k = 1; k <= DIV_STAGES; k++) begin : g_div
      logic [DIM_W:0] ta, tb, sa, sb;
      logic           gea, geb;
      logic [DIM_W-1:0] d;
      always_comb begin
        d = (stg_r[k-1].action == ACT_NEIGHBOURS) ? status.column_count
                                                   : {3'b0, status.cell_size};
        ta = {stg_r[k-1].ra, stg_r[k-1].na[CELL_W-1]};
        tb = {stg_r[k-1].rb, stg_r[k-1].nb[CELL_W-1]};
        gea = ta >= {1'b0, d};
        geb = tb >= {1'b0, d};
        sa = ta - {1'b0, d};
        sb = tb - {1'b0, d};
        stg_nxt[k] = stg_r[k-1];
        stg_nxt[k].na = {stg_r[k-1].na[CELL_W-2:0], gea};
        stg_nxt[k].nb = {stg_r[k-1].nb[CELL_W-2:0], geb};
        stg_nxt[k].ra = gea ? sa[DIM_W-1:0] : ta[DIM_W-1:0];
        stg_nxt[k].rb = geb ? sb[DIM_W-1:0] : tb[DIM_W-1:0];
      end
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          stg_r[k] <= '0;
        end else if (adv) begin
          stg_r[k] <= stg_nxt[k];
        end
      end
    end
  endgenerate

  assign divisor = status.column_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r[0] <= '0;
    end else if (adv) begin
      stg_r[0].valid <= accept;
      stg_r[0].action <= in_data.action;
      stg_r[0].a_ok <= in_data.first_cell < status.total;
      stg_r[0].b_ok <= in_data.second_cell < status.total;
      stg_r[0].a_idx <= in_data.first_cell[IDX_W-1:0];
      stg_r[0].na <= (in_data.action == ACT_NEIGHBOURS) ? in_data.first_cell
                                                        : CELL_W'(in_data.pos_x);
      stg_r[0].nb <= (in_data.action == ACT_NEIGHBOURS) ? in_data.second_cell
                                                        : CELL_W'(in_data.pos_y);
      stg_r[0].ra <= '0;
      stg_r[0].rb <= '0;
    end
  end

  // mask and row bases for the sequencer
  div_stage_t       s;
  logic [DIM_W-1:0] lx, ly, ax, ay, bx, by;
  logic [2*DIM_W-1:0] prod;
  logic [IDX_W-1:0] loc_idx;
  logic [2:0]       row_ok, col_ok, near_x, near_y;
  logic signed [DIM_W+1:0] dxs, dys, vx, vy;
  logic [8:0]       mask_nxt;

  always_comb begin
    s = stg_r[DIV_STAGES];
    lx = (s.na >= CELL_W'(status.column_count)) ? '0 : s.na[DIM_W-1:0];
    ly = (s.nb >= CELL_W'(status.row_count)) ? '0 : s.nb[DIM_W-1:0];
    prod = ly * status.column_count;
    loc_idx = IDX_W'(prod) + IDX_W'(lx);
    ax = s.ra;
    ay = s.na[DIM_W-1:0];
    bx = s.rb;
    by = s.nb[DIM_W-1:0];
    row_ok[0] = (ay != '0);
    row_ok[1] = 1'b1;
    row_ok[2] = ({1'b0, ay} + (DIM_W+1)'(1)) < {1'b0, status.row_count};
    col_ok[0] = (ax != '0);
    col_ok[1] = 1'b1;
    col_ok[2] = ({1'b0, ax} + (DIM_W+1)'(1)) < {1'b0, divisor};
    dxs = $signed({2'b0, ax}) - $signed({2'b0, bx});
    dys = $signed({2'b0, ay}) - $signed({2'b0, by});
    for (int j = 0; j < 3; j++) begin
      vx = dxs + (DIM_W+2)'(j - 1);
      vy = dys + (DIM_W+2)'(j - 1);
      near_x[j] = (vx >= -(DIM_W+2)'(1)) && (vx <= (DIM_W+2)'(1));
      near_y[j] = (vy >= -(DIM_W+2)'(1)) && (vy <= (DIM_W+2)'(1));
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mask_nxt[i*3+j] = s.a_ok && row_ok[i] && col_ok[j]
                          && !(s.b_ok && near_y[i] && near_x[j]);
      end
    end
    if (!s.valid) begin
      mask_nxt = '0;
    end else if (s.action == ACT_LOCATE) begin
      mask_nxt = 9'b000010000;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_mask_r <= '0;
    end else if (adv) begin
      em_mask_r <= mask_nxt;
    end else begin
      em_mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      em_base_r[0] <= s.a_idx - IDX_W'(divisor);
      em_base_r[1] <= (s.action == ACT_LOCATE) ? loc_idx : s.a_idx;
      em_base_r[2] <= s.a_idx + IDX_W'(divisor);
    end
  end

  // lowest pending cell first
  logic [1:0] sel_row, sel_col;
  always_comb begin
    sel_row = 2'd0;
    sel_col = 2'd0;
    for (int p = 8; p >= 0; p--) begin
      if (em_mask_r[p]) begin
        sel_row = 2'(p / 3);
        sel_col = 2'(p % 3);
      end
    end
  end

  assign out_strobe = (em_mask_r != '0);
  assign out_data.cell_index = em_base_r[sel_row] + IDX_W'(sel_col) - IDX_W'(1);
  assign out_data.last = (mask_rest == '0);

endmodule
`default_nettype wire
